// ----- design/pmm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmm_pkg
// Types and fixed constants of the paged memory map: request and response
// payloads, operation codes, controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package pmm_pkg;

  localparam logic [15:0] SRAM_BASE   = 16'hF800;
  localparam logic [15:0] PROM_BASE   = 16'hFC00;
  localparam logic [7:0]  OPEN_BUS    = 8'hFF;
  localparam int          LOCAL_BYTES = 1024;
  localparam int          LOCAL_AW    = 10;
  localparam logic [5:0]  RAM_PAGES_RESET = 6'd48;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_POKE  = 2'd2,
    OP_CHECK = 2'd3
  } pmm_op_e;

  typedef struct packed {
    pmm_op_e     operation;
    logic [15:0] address;
    logic [7:0]  write_data;
  } pmm_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       socket_loaded;
  } pmm_rsp_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic scan;
    logic finish;
  } pmm_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic check_prom;
  } pmm_sts_t;

endpackage

// ----- design/pmm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmm_ctrl
// Controller of the memory map: clearing pass after reset, request
// acceptance, PROM socket scan sequencing and the response valid flag.
// ----------------------------------------------------------------------------
module pmm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  pmm_pkg::pmm_sts_t sts_i,
  output pmm_pkg::pmm_cmd_t cmd_o
);
  import pmm_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;
  logic       accept;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) && slot_free);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = accept;
    state_d      = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && sts_i.check_prom) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == ST_FINISH) begin
      out_valid_d = 1'b1;
    end else if (accept) begin
      out_valid_d = !sts_i.check_prom;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_check_enters_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && sts_i.check_prom) |=> (state_q == ST_SCAN))
    else $error("prom check did not start a socket scan");

  a_finish_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |=> out_valid_q)
    else $error("socket scan finished without a response");

  a_scan_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN || state_q == ST_FINISH) |-> !out_valid_q)
    else $error("response pending while the socket scan runs");

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (state_q == ST_IDLE) && !cmd_o.clear)
    else $error("request taken outside idle");

endmodule

// ----- design/pmm_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmm_dp
// Datapath of the memory map: main RAM, SRAM and PROM arrays, address
// decode, page register, shared clear/scan counter and response registers.
// ----------------------------------------------------------------------------
module pmm_dp #(
  parameter int PAGE_BYTES    = 1024,
  parameter int PAGE_COUNT    = 64,
  parameter int MAX_RAM_PAGES = 62,
  parameter int SOCKET_BYTES  = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pmm_pkg::pmm_cmd_t cmd_i,
  input  pmm_pkg::pmm_req_t req_i,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_wdata_i,
  output pmm_pkg::pmm_rsp_t rsp_o,
  output pmm_pkg::pmm_sts_t sts_o
);
  import pmm_pkg::*;

  localparam int MAIN_FULL  = MAX_RAM_PAGES * PAGE_BYTES;
  localparam int MAIN_DEPTH = (MAIN_FULL < 32'h0000F800) ? MAIN_FULL : 32'h0000F800;
  localparam int MAIN_AW    = $clog2(MAIN_DEPTH);
  localparam int CLR_LEN    = (MAIN_DEPTH > LOCAL_BYTES) ? MAIN_DEPTH : LOCAL_BYTES;
  localparam int CNT_W      = $clog2(CLR_LEN);
  localparam int PB_W       = $clog2(PAGE_BYTES);
  localparam int MAP_LIMIT  = (MAX_RAM_PAGES < PAGE_COUNT) ? MAX_RAM_PAGES : PAGE_COUNT;
  localparam logic [LOCAL_AW-1:0] SOCK_MASK = LOCAL_AW'(LOCAL_BYTES - SOCKET_BYTES);

  localparam logic [2:0] SEL_ZERO = 3'd0;
  localparam logic [2:0] SEL_OPEN = 3'd1;
  localparam logic [2:0] SEL_MAIN = 3'd2;
  localparam logic [2:0] SEL_SRAM = 3'd3;
  localparam logic [2:0] SEL_PROM = 3'd4;

  logic [7:0] main_mem_q [MAIN_DEPTH];
  logic [7:0] sram_mem_q [LOCAL_BYTES];
  logic [7:0] prom_mem_q [LOCAL_BYTES];

  logic [7:0]          main_rd_q, sram_rd_q, prom_rd_q;
  logic [5:0]          ram_pages_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [2:0]          sel_q, sel_d;
  logic                sock_q, hit_q;
  logic [LOCAL_AW-1:0] sock_base_q;

  logic [15:0]         addr;
  logic [15:0]         page;
  logic [15:0]         mapped;
  logic                in_main, in_sram, in_prom, is_store;
  logic                cnt_in_main, cnt_in_local;
  logic                main_we, sram_we, prom_we;
  logic [MAIN_AW-1:0]  main_wa;
  logic [LOCAL_AW-1:0] local_wa, prom_ra;
  logic [7:0]          main_wd, sram_wd, prom_wd;

  assign addr    = req_i.address;
  assign page    = addr >> PB_W;
  assign mapped  = (16'(ram_pages_q) < 16'(MAP_LIMIT)) ? 16'(ram_pages_q) : 16'(MAP_LIMIT);
  assign in_prom = addr >= PROM_BASE;
  assign in_sram = (addr >= SRAM_BASE) && !in_prom;
  assign in_main = (addr < SRAM_BASE) && (page < mapped)
                   && ({1'b0, addr} < 17'(MAIN_DEPTH));
  assign is_store = (req_i.operation == OP_WRITE) || (req_i.operation == OP_POKE);

  assign cnt_in_main  = {1'b0, cnt_q} < (CNT_W+1)'(MAIN_DEPTH);
  assign cnt_in_local = {1'b0, cnt_q} < (CNT_W+1)'(LOCAL_BYTES);

  assign sts_o.clear_last = cnt_q == CNT_W'(CLR_LEN - 1);
  assign sts_o.scan_last  = cnt_q == CNT_W'(SOCKET_BYTES - 1);
  assign sts_o.check_prom = (req_i.operation == OP_CHECK) && in_prom;

  // write ports, shared between the clearing pass and requests
  always_comb begin
    main_we  = 1'b0;
    sram_we  = 1'b0;
    prom_we  = 1'b0;
    main_wa  = addr[MAIN_AW-1:0];
    local_wa = addr[LOCAL_AW-1:0];
    main_wd  = req_i.write_data;
    sram_wd  = req_i.write_data;
    prom_wd  = req_i.write_data;
    if (cmd_i.clear) begin
      main_we  = cnt_in_main;
      sram_we  = cnt_in_local;
      prom_we  = cnt_in_local;
      main_wa  = cnt_q[MAIN_AW-1:0];
      local_wa = cnt_q[LOCAL_AW-1:0];
      main_wd  = 8'h00;
      sram_wd  = 8'h00;
      prom_wd  = OPEN_BUS;
    end else if (cmd_i.accept) begin
      main_we = is_store && in_main;
      sram_we = is_store && in_sram;
      prom_we = (req_i.operation == OP_POKE) && in_prom;
    end
  end

  assign prom_ra = cmd_i.scan ? (sock_base_q | cnt_q[LOCAL_AW-1:0]) : addr[LOCAL_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (main_we) main_mem_q[main_wa] <= main_wd;
    if (sram_we) sram_mem_q[local_wa] <= sram_wd;
    if (prom_we) prom_mem_q[local_wa] <= prom_wd;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      main_rd_q <= main_mem_q[addr[MAIN_AW-1:0]];
      sram_rd_q <= sram_mem_q[addr[LOCAL_AW-1:0]];
    end
    if (cmd_i.accept || cmd_i.scan) prom_rd_q <= prom_mem_q[prom_ra];
  end

  always_comb begin
    sel_d = SEL_ZERO;
    if (req_i.operation == OP_READ) begin
      if (in_prom)      sel_d = SEL_PROM;
      else if (in_sram) sel_d = SEL_SRAM;
      else if (in_main) sel_d = SEL_MAIN;
      else              sel_d = SEL_OPEN;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear) begin
      cnt_d = sts_o.clear_last ? '0 : cnt_q + 1'b1;
    end else if (cmd_i.scan) begin
      cnt_d = sts_o.scan_last ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_pages_q <= RAM_PAGES_RESET;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) ram_pages_q <= cfg_wdata_i;
      cnt_q <= cnt_d;
    end
  end

  // response registers and socket scan accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sel_q       <= sel_d;
      sock_q      <= 1'b0;
      hit_q       <= 1'b0;
      sock_base_q <= addr[LOCAL_AW-1:0] & SOCK_MASK;
    end else if (cmd_i.scan) begin
      if (cnt_q != '0) hit_q <= hit_q | (prom_rd_q != OPEN_BUS);
    end else if (cmd_i.finish) begin
      sock_q <= hit_q | (prom_rd_q != OPEN_BUS);
    end
  end

  always_comb begin
    case (sel_q)
      SEL_OPEN: rsp_o.read_data = OPEN_BUS;
      SEL_MAIN: rsp_o.read_data = main_rd_q;
      SEL_SRAM: rsp_o.read_data = sram_rd_q;
      SEL_PROM: rsp_o.read_data = prom_rd_q;
      default:  rsp_o.read_data = 8'h00;
    endcase
  end

  assign rsp_o.socket_loaded = sock_q;

endmodule

// ----- design/paged_memory_map_with_prom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_memory_map_with_prom
// Memory map of a 64 KiB byte-wide machine: paged main RAM from zero, SRAM
// at F800h, PROM at FC00h, open bus elsewhere.
//
// Requests enter on in_valid_i/in_stall_o carrying operation, address and
// write data; one response per request leaves on out_valid_o/out_stall_i.
// ram_pages is written through cfg_we_i/cfg_wdata_i; the user writes it only
// while the block is idle, as the block itself does not enforce this.
// Read, write, poke and a check below PROM answer in the cycle after
// acceptance, and a new request is taken every cycle as long as the
// response register is free or being emptied in the same cycle.
// A PROM socket check on a PROM address walks the socket through the PROM's
// single read port, byte by byte, and then sets the response; no other
// request is taken meanwhile. After reset a clearing pass zeroes RAM and
// SRAM and sets PROM to FFh; in_stall_o stays high until it ends. While
// out_stall_i holds a response, the response stays unchanged and
// in_stall_o rises.
// ----------------------------------------------------------------------------
module paged_memory_map_with_prom #(
  parameter int PAGE_BYTES    = 1024,
  parameter int PAGE_COUNT    = 64,
  parameter int MAX_RAM_PAGES = 62,
  parameter int SOCKET_BYTES  = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pmm_pkg::pmm_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pmm_pkg::pmm_rsp_t out_rsp_o,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_wdata_i
);
  import pmm_pkg::*;

  pmm_cmd_t cmd;
  pmm_sts_t sts;

  pmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pmm_dp #(
    .PAGE_BYTES    (PAGE_BYTES),
    .PAGE_COUNT    (PAGE_COUNT),
    .MAX_RAM_PAGES (MAX_RAM_PAGES),
    .SOCKET_BYTES  (SOCKET_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (out_rsp_o),
    .sts_o       (sts)
  );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the paged memory map. A mirror of RAM, SRAM and
// PROM predicts every response. Directed accesses at the map edges come
// first, then random traffic under several ram_pages settings, with random
// gaps on the request side and back-pressure on the response side.
// ----------------------------------------------------------------------------
module tb_top;
  import pmm_pkg::*;

  localparam int PAGE_BYTES    = 1024;
  localparam int PAGE_COUNT    = 64;
  localparam int MAX_RAM_PAGES = 62;
  localparam int SOCKET_BYTES  = 256;
  localparam int MAIN_BYTES    = MAX_RAM_PAGES * PAGE_BYTES;
  localparam int PHASE_ITEMS   = 175;
  localparam int LONG_HOLD     = 400;
  localparam int IDLE_LIMIT    = 262144;

  class mem_map_mirror;
    logic [7:0] main_ram [MAIN_BYTES];
    logic [7:0] sram [LOCAL_BYTES];
    logic [7:0] prom [LOCAL_BYTES];
    logic [5:0] ram_pages;
    pmm_rsp_t   expected_rsp [$];
    int         mismatches;
    int         checked;

    function new();
      foreach (main_ram[i]) main_ram[i] = 8'h00;
      foreach (sram[i]) sram[i] = 8'h00;
      foreach (prom[i]) prom[i] = OPEN_BUS;
      ram_pages  = RAM_PAGES_RESET;
      mismatches = 0;
      checked    = 0;
    endfunction

    function automatic bit in_main(int unsigned a);
      int unsigned mapped;
      mapped = (ram_pages > MAX_RAM_PAGES) ? MAX_RAM_PAGES : ram_pages;
      return (a < SRAM_BASE) && ((a / PAGE_BYTES) < mapped) && (a < MAIN_BYTES);
    endfunction

    function automatic pmm_rsp_t predict_rsp(pmm_req_t r);
      pmm_rsp_t    rsp;
      int unsigned a;
      int unsigned off;
      rsp = '0;
      a   = r.address;
      case (r.operation)
        OP_READ: begin
          if (a >= PROM_BASE) rsp.read_data = prom[a - PROM_BASE];
          else if (a >= SRAM_BASE) rsp.read_data = sram[a - SRAM_BASE];
          else if (in_main(a)) rsp.read_data = main_ram[a];
          else rsp.read_data = OPEN_BUS;
        end
        OP_WRITE, OP_POKE: begin
          if (a >= PROM_BASE) begin
            if (r.operation == OP_POKE) prom[a - PROM_BASE] = r.write_data;
          end else if (a >= SRAM_BASE) begin
            sram[a - SRAM_BASE] = r.write_data;
          end else if (in_main(a)) begin
            main_ram[a] = r.write_data;
          end
        end
        default: begin
          if (a >= PROM_BASE) begin
            off = a - PROM_BASE;
            off = off - off % SOCKET_BYTES;
            for (int k = 0; k < SOCKET_BYTES; k++)
              if (prom[off + k] != OPEN_BUS) rsp.socket_loaded = 1'b1;
          end
        end
      endcase
      return rsp;
    endfunction

    function void note_request(pmm_req_t r);
      expected_rsp.push_back(predict_rsp(r));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_response(pmm_rsp_t got);
      pmm_rsp_t want;
      if (expected_rsp.size() == 0) begin
        report($sformatf("unexpected response %h", got));
        return;
      end
      want = expected_rsp.pop_front();
      if (got.read_data !== want.read_data)
        report($sformatf("response %0d read_data %h, expected %h",
                         checked, got.read_data, want.read_data));
      if (got.socket_loaded !== want.socket_loaded)
        report($sformatf("response %0d socket_loaded %b, expected %b",
                         checked, got.socket_loaded, want.socket_loaded));
      checked++;
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  pmm_req_t   in_req_i;
  logic       out_valid_o;
  logic       out_stall_i;
  pmm_rsp_t   out_rsp_o;
  logic       cfg_we_i;
  logic [5:0] cfg_wdata_i;

  mem_map_mirror mirror;
  bit            steady;
  bit            hold_off_req;
  int            idle_cycles;

  paged_memory_map_with_prom #(
    .PAGE_BYTES    (PAGE_BYTES),
    .PAGE_COUNT    (PAGE_COUNT),
    .MAX_RAM_PAGES (MAX_RAM_PAGES),
    .SOCKET_BYTES  (SOCKET_BYTES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  function automatic pmm_req_t mk(pmm_op_e op, logic [15:0] addr, logic [7:0] data);
    pmm_req_t r;
    r.operation  = op;
    r.address    = addr;
    r.write_data = data;
    return r;
  endfunction

  function automatic pmm_req_t make_req();
    pmm_req_t    r;
    int unsigned pick;
    int unsigned bound;
    int unsigned page;
    int unsigned offs;
    r.write_data = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 35) r.operation = OP_READ;
    else if (pick < 65) r.operation = OP_WRITE;
    else if (pick < 85) r.operation = OP_POKE;
    else r.operation = OP_CHECK;
    offs = $urandom_range(0, 1) ? $urandom_range(0, PAGE_BYTES - 1)
                                : $urandom_range(0, 7) + ($urandom_range(0, 1) ? 1016 : 0);
    case ($urandom_range(0, 9))
      0, 1: r.address = 16'($urandom_range(0, 16'hFFFF));
      2, 3: begin
        // around the top of mapped RAM
        bound = (mirror.ram_pages > MAX_RAM_PAGES) ? MAX_RAM_PAGES : mirror.ram_pages;
        page  = (bound == 0) ? $urandom_range(0, 1) : bound - 1 + $urandom_range(0, 1);
        r.address = 16'((page * PAGE_BYTES) + offs);
      end
      4: r.address = 16'($urandom_range(0, 255));
      5, 6: r.address = SRAM_BASE + 16'(offs);
      default: begin
        if (r.operation == OP_POKE || $urandom_range(0, 1)) begin
          // first and last byte of each socket so sockets fill and empty again
          r.address = PROM_BASE + 16'(($urandom_range(0, 3) * SOCKET_BYTES) +
                                      ($urandom_range(0, 1) ? SOCKET_BYTES - 1 : 0));
          if (r.operation == OP_POKE && $urandom_range(0, 1)) r.write_data = OPEN_BUS;
        end else begin
          r.address = PROM_BASE + 16'($urandom_range(0, LOCAL_BYTES - 1));
        end
      end
    endcase
    return r;
  endfunction

  task automatic issue(input pmm_req_t r);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    mirror.note_request(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (mirror.expected_rsp.size() != 0);
  endtask

  task automatic set_ram_pages(input logic [5:0] v);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i         <= 1'b0;
    mirror.ram_pages = v;
  endtask

  task automatic run_directed();
    issue(mk(OP_READ,  16'h0000, 8'h00));
    issue(mk(OP_READ,  16'hFFFF, 8'hFF));
    issue(mk(OP_CHECK, 16'hFC00, 8'h00));
    issue(mk(OP_WRITE, 16'hFC10, 8'h12));
    issue(mk(OP_READ,  16'hFC10, 8'h00));
    issue(mk(OP_CHECK, 16'hFC10, 8'hFF));
    issue(mk(OP_POKE,  16'hFC10, 8'h00));
    issue(mk(OP_CHECK, 16'hFC80, 8'h00));
    issue(mk(OP_CHECK, 16'hFD00, 8'h00));
    issue(mk(OP_READ,  16'hFC10, 8'h00));
    issue(mk(OP_POKE,  16'hFC10, 8'hFF));
    issue(mk(OP_CHECK, 16'hFCFF, 8'h00));
    issue(mk(OP_WRITE, 16'hF800, 8'hA5));
    issue(mk(OP_READ,  16'hF800, 8'h00));
    issue(mk(OP_WRITE, 16'hFBFF, 8'h5A));
    issue(mk(OP_READ,  16'hFBFF, 8'hFF));
    issue(mk(OP_WRITE, 16'hBFFF, 8'hFF));
    issue(mk(OP_READ,  16'hBFFF, 8'h00));
    issue(mk(OP_WRITE, 16'hC000, 8'h33));
    issue(mk(OP_READ,  16'hC000, 8'h00));
    issue(mk(OP_CHECK, 16'h1234, 8'hFF));
    issue(mk(OP_POKE,  16'h0010, 8'h77));
    issue(mk(OP_READ,  16'h0010, 8'hFF));
    issue(mk(OP_READ,  16'hF7FF, 8'hFF));
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      if (i == 40) hold_off_req = 1'b1;
      if ($urandom_range(0, 99) == 0) begin
        drain();
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_len()) @(posedge clk_i);
      end
      issue(make_req());
    end
  endtask

  // receiver back-pressure
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat (gap_len()) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) mirror.check_response(out_rsp_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    mirror       = new();
    steady       = 1'b0;
    hold_off_req = 1'b0;
    idle_cycles  = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_req_i    <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    set_ram_pages(6'd0);
    run_random(PHASE_ITEMS);
    set_ram_pages(6'd62);
    run_random(PHASE_ITEMS);
    set_ram_pages(6'd63);
    run_random(PHASE_ITEMS);
    set_ram_pages(6'd1);
    run_random(PHASE_ITEMS);
    set_ram_pages(6'd31);
    run_random(PHASE_ITEMS);
    set_ram_pages(6'($urandom_range(0, 63)));
    run_random(PHASE_ITEMS);
    set_ram_pages(6'd48);
    run_random(PHASE_ITEMS);

    drain();
    repeat (SOCKET_BYTES + 16) @(posedge clk_i);
    if (mirror.expected_rsp.size() != 0)
      mirror.report($sformatf("%0d responses missing", mirror.expected_rsp.size()));
    if (mirror.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
